/* rtl/min_removal_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// min_removal_queue_top_defines
// assertion macros used by the queue top
// ----------------------------------------------------------------------------
`ifndef MIN_REMOVAL_QUEUE_TOP_DEFINES_SVH
`define MIN_REMOVAL_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mrq_pkg.sv */
// ----------------------------------------------------------------------------
// mrq_pkg
// types and constants of the min removal queue
// ----------------------------------------------------------------------------
package mrq_pkg;

    localparam int DEPTH  = 16;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    localparam logic [CMD_W-1:0] CMD_ENQUEUE      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_MIN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic [IDX_W-1:0]        index_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } cell_ctrl_t;

endpackage

/* rtl/mrq_cmd_if.sv */
// ----------------------------------------------------------------------------
// mrq_cmd_if
// command channel: one transaction per queue command
// ----------------------------------------------------------------------------
interface mrq_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [mrq_pkg::CMD_W-1:0]      command;
    mrq_pkg::value_t                value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

/* rtl/mrq_res_if.sv */
// ----------------------------------------------------------------------------
// mrq_res_if
// result channel: one transaction per completed command
// ----------------------------------------------------------------------------
interface mrq_res_if;
    logic                           valid;
    logic                           ready;
    logic [mrq_pkg::STAT_W-1:0]     status;
    mrq_pkg::value_t                removed_value;
    mrq_pkg::count_t                entry_count;
    logic                           is_empty;

    modport source (output valid, output status, output removed_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entry_count, input is_empty, output ready);
endinterface

/* rtl/mrq_cell.sv */
// ----------------------------------------------------------------------------
// mrq_cell
// one queue slot: loads a new value, takes its right neighbour or the front
// ----------------------------------------------------------------------------
module mrq_cell (
    input  logic                clk,
    input  mrq_pkg::cell_ctrl_t ctrl,
    input  mrq_pkg::value_t     load_val,
    input  mrq_pkg::value_t     right_val,
    input  mrq_pkg::value_t     front_val,
    output mrq_pkg::value_t     val
);

    mrq_pkg::value_t val_reg;
    mrq_pkg::value_t val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load)
        begin
            val_next = load_val;
        end
        else if (ctrl.shift)
        begin
            // rear of the ring picks up the entry leaving the front
            val_next = ctrl.wrap ? front_val : right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* rtl/min_removal_queue_top.sv */
// ----------------------------------------------------------------------------
// min_removal_queue_top
// arrival-ordered queue with remove-minimum and remove-front
// ----------------------------------------------------------------------------
// Holds up to DEPTH signed values, oldest at the front, in a row of cells
// that shift towards the front. Enqueue, remove-front, an unused command and
// any removal from an empty queue finish directly: the result sits in the
// output register on the next edge. For remove-minimum the cells rotate as a
// ring, one entry per cycle past a single comparator at the front (the last
// delete step waits for a free result register): a search pass finds the
// smallest value and a delete pass rotates again and drops it on the way. In
// idle, a command is taken while the result register is empty or being drained.
module min_removal_queue_top (
    input  logic       clk,
    input  logic       rst_n,
    mrq_cmd_if.sink    cmd,
    mrq_res_if.source  res
);

    `include "min_removal_queue_top_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DELETE
    } state_t;

    state_t                       state_reg, state_next;
    mrq_pkg::count_t              occ_reg, occ_next;
    mrq_pkg::index_t              step_reg, step_next;
    mrq_pkg::index_t              best_idx_reg, best_idx_next;
    mrq_pkg::value_t              best_val_reg, best_val_next;

    logic                         res_valid_reg, res_valid_next;
    logic [mrq_pkg::STAT_W-1:0]   status_reg, status_next;
    mrq_pkg::value_t              removed_reg, removed_next;
    mrq_pkg::count_t              count_reg, count_next;

    mrq_pkg::cell_ctrl_t          ctrl [mrq_pkg::DEPTH];
    mrq_pkg::value_t              cell_val [mrq_pkg::DEPTH];
    mrq_pkg::value_t              front;

    logic                         out_free;
    logic                         cmd_acc;
    logic                         last_step;
    logic                         step_go;
    logic                         do_shift;
    logic                         drop_front;
    mrq_pkg::count_t              wrap_pos;

    assign front    = cell_val[0];
    assign out_free = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign last_step = (mrq_pkg::count_t'(step_reg) == occ_reg - 1'b1);
    assign step_go   = !last_step || out_free;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        step_next      = step_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        res_valid_next = res_valid_reg && !res.ready;
        status_next    = status_reg;
        removed_next   = removed_reg;
        count_next     = count_reg;
        do_shift       = 1'b0;
        drop_front     = 1'b0;
        wrap_pos       = occ_reg - 1'b1;
        for (int i = 0; i < mrq_pkg::DEPTH; i++)
        begin
            ctrl[i] = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    res_valid_next = 1'b1;
                    status_next    = mrq_pkg::STAT_OK;
                    removed_next   = '0;
                    count_next     = occ_reg;
                    case (cmd.command)
                        mrq_pkg::CMD_ENQUEUE:
                        begin
                            if (occ_reg == mrq_pkg::count_t'(mrq_pkg::DEPTH))
                            begin
                                status_next = mrq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < mrq_pkg::DEPTH; i++)
                                begin
                                    ctrl[i].load = (mrq_pkg::count_t'(i) == occ_reg);
                                end
                                occ_next   = occ_reg + 1'b1;
                                count_next = occ_reg + 1'b1;
                            end
                        end
                        mrq_pkg::CMD_REMOVE_FRONT:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = mrq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                do_shift     = 1'b1;
                                drop_front   = 1'b1;
                                removed_next = front;
                                occ_next     = occ_reg - 1'b1;
                                count_next   = occ_reg - 1'b1;
                            end
                        end
                        mrq_pkg::CMD_REMOVE_MIN:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = mrq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // result comes at the end of the delete pass
                                res_valid_next = 1'b0;
                                state_next     = ST_SEARCH;
                                step_next      = '0;
                            end
                        end
                        default:
                        begin
                            status_next = mrq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                do_shift = 1'b1;
                // strict compare keeps the earliest arrival on a tie
                if (step_reg == '0 || front < best_val_reg)
                begin
                    best_val_next = front;
                    best_idx_next = step_reg;
                end
                if (last_step)
                begin
                    state_next = ST_DELETE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DELETE:
            begin
                if (step_go)
                begin
                    do_shift = 1'b1;
                    if (step_reg == best_idx_reg)
                    begin
                        drop_front = 1'b1;
                    end
                    else if (step_reg > best_idx_reg)
                    begin
                        // ring is one shorter once the minimum has gone
                        wrap_pos = occ_reg - 2'd2;
                    end
                    if (last_step)
                    begin
                        state_next     = ST_IDLE;
                        occ_next       = occ_reg - 1'b1;
                        res_valid_next = 1'b1;
                        status_next    = mrq_pkg::STAT_OK;
                        removed_next   = best_val_reg;
                        count_next     = occ_reg - 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_shift)
        begin
            for (int i = 0; i < mrq_pkg::DEPTH; i++)
            begin
                ctrl[i].shift = 1'b1;
                ctrl[i].wrap  = !drop_front && (mrq_pkg::count_t'(i) == wrap_pos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            step_reg      <= '0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= mrq_pkg::STAT_OK;
            removed_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            step_reg      <= step_next;
            best_idx_reg  <= best_idx_next;
            best_val_reg  <= best_val_next;
            res_valid_reg <= res_valid_next;
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            count_reg     <= count_next;
        end
    end

    for (genvar g = 0; g < mrq_pkg::DEPTH; g++)
    begin : g_cell
        mrq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[g]),
            .load_val  (cmd.value),
            .right_val (cell_val[(g + 1 < mrq_pkg::DEPTH) ? g + 1 : g]),
            .front_val (front),
            .val       (cell_val[g])
        );
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.entry_count   = count_reg;
    assign res.is_empty      = (count_reg == '0);

    `MRQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= mrq_pkg::count_t'(mrq_pkg::DEPTH),
        "occupancy above depth")
    `MRQ_ASSERT_NOW(a_walk_nonempty, state_reg != ST_IDLE,
        occ_reg != '0 && mrq_pkg::count_t'(step_reg) < occ_reg,
        "ring walk outside stored entries")
    `MRQ_ASSERT_NEXT(a_min_shrinks, state_reg == ST_DELETE && step_go && last_step,
        occ_reg == $past(occ_reg) - 1'b1 && res.valid && res.status == mrq_pkg::STAT_OK,
        "remove-minimum did not take exactly one entry")
    `MRQ_ASSERT_NEXT(a_enq_grows,
        cmd_acc && cmd.command == mrq_pkg::CMD_ENQUEUE
            && occ_reg != mrq_pkg::count_t'(mrq_pkg::DEPTH),
        occ_reg == $past(occ_reg) + 1'b1 && res.entry_count == occ_reg,
        "enqueue did not grow the queue")

endmodule

/* tb/sv/min_removal_queue_checker.sv */
// ----------------------------------------------------------------------------
// min_removal_queue_checker
// watches the command and result channels, predicts each result and
// compares it field by field with what the queue returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_removal_queue_checker (
    input  logic  clk,
    input  logic  rst_n,
    mrq_cmd_if    cmd_mon,
    mrq_res_if    res_mon,
    output int    fails,
    output int    outstanding,
    output int    results_seen,
    output int    full_drops,
    output int    empty_hits
);

    typedef struct packed {
        logic [mrq_pkg::STAT_W-1:0] status;
        mrq_pkg::value_t            removed_value;
        mrq_pkg::count_t            entry_count;
        logic                       is_empty;
    } queue_result_t;

    // predicted queue contents, oldest first
    mrq_pkg::value_t held_values[$];
    queue_result_t   pending_results[$];
    queue_result_t   oldest;

    int fail_tally   = 0;
    int result_tally = 0;
    int full_tally   = 0;
    int empty_tally  = 0;

    // applies one command to the predicted queue and returns its result
    function automatic queue_result_t queue_after_command(
        input logic [mrq_pkg::CMD_W-1:0] code,
        input mrq_pkg::value_t           val
    );
        queue_result_t r;
        int            pick;
        r.status        = mrq_pkg::STAT_OK;
        r.removed_value = '0;
        case (code) inside
            mrq_pkg::CMD_ENQUEUE:
            begin
                if (held_values.size() >= mrq_pkg::DEPTH)
                    r.status = mrq_pkg::STAT_FULL;
                else
                    held_values.push_back(val);
            end
            mrq_pkg::CMD_REMOVE_MIN, mrq_pkg::CMD_REMOVE_FRONT:
            begin
                if (held_values.size() == 0)
                    r.status = mrq_pkg::STAT_EMPTY;
                else
                begin
                    pick = 0;
                    // strict less-than keeps the earliest arrival on a tie
                    if (code == mrq_pkg::CMD_REMOVE_MIN)
                        for (int i = 1; i < held_values.size(); i++)
                            if (held_values[i] < held_values[pick])
                                pick = i;
                    r.removed_value = held_values[pick];
                    held_values.delete(pick);
                end
            end
            default: ;
        endcase
        r.entry_count = mrq_pkg::count_t'(held_values.size());
        r.is_empty    = (held_values.size() == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result taken at this edge always belongs to an earlier command
            if (res_mon.valid && res_mon.ready)
            begin
                result_tally++;
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    fail_tally++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (res_mon.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, res_mon.status);
                        fail_tally++;
                    end
                    if (res_mon.removed_value !== oldest.removed_value)
                    begin
                        $error("removed_value: expected %0d, got %0d",
                               oldest.removed_value, res_mon.removed_value);
                        fail_tally++;
                    end
                    if (res_mon.entry_count !== oldest.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               oldest.entry_count, res_mon.entry_count);
                        fail_tally++;
                    end
                    if (res_mon.is_empty !== oldest.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d",
                               oldest.is_empty, res_mon.is_empty);
                        fail_tally++;
                    end
                end
            end

            if (cmd_mon.valid && cmd_mon.ready)
            begin
                oldest = queue_after_command(cmd_mon.command, cmd_mon.value);
                if (oldest.status == mrq_pkg::STAT_FULL)
                    full_tally++;
                if (oldest.status == mrq_pkg::STAT_EMPTY)
                    empty_tally++;
                pending_results.push_back(oldest);
            end
        end

        fails        <= fail_tally;
        outstanding  <= pending_results.size();
        results_seen <= result_tally;
        full_drops   <= full_tally;
        empty_hits   <= empty_tally;
    end

endmodule

/* tb/sv/min_removal_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// min_removal_queue_top_tb
// drives directed and random queue commands with random gaps on both
// channels, one long result hold-off, and reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_removal_queue_top_tb;

    localparam logic [mrq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS    = 1900;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     HOLD_OFF_AFTER  = 500;
    localparam int     DRAIN_CYCLES    = 2 * mrq_pkg::DEPTH + 8;
    localparam int     CYCLE_LIMIT     = 1000000;
    localparam mrq_pkg::value_t VAL_MIN = {1'b1, {(mrq_pkg::VAL_W-1){1'b0}}};
    localparam mrq_pkg::value_t VAL_MAX = {1'b0, {(mrq_pkg::VAL_W-1){1'b1}}};

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} traffic_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    int fails;
    int outstanding;
    int results_seen;
    int full_drops;
    int empty_hits;
    int cycle_count   = 0;
    int commands_sent = 0;

    mrq_cmd_if cmd_if ();
    mrq_res_if res_if ();

    min_removal_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    min_removal_queue_checker queue_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_mon      (cmd_if),
        .res_mon      (res_if),
        .fails        (fails),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .full_drops   (full_drops),
        .empty_hits   (empty_hits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic mrq_pkg::value_t random_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            // narrow range so that equal values meet often
            1, 2, 3, 4: return mrq_pkg::value_t'($signed($urandom_range(0, 15)) - 8);
            default:    return mrq_pkg::value_t'($urandom());
        endcase
    endfunction

    function automatic logic [mrq_pkg::CMD_W-1:0] random_command(input traffic_phase_t ph);
        int enq_pct;
        if ($urandom_range(0, 99) < 3)
            return CMD_UNUSED;
        enq_pct = (ph == PH_FILL) ? 80 : (ph == PH_DRAIN) ? 20 : 50;
        if ($urandom_range(0, 99) < enq_pct)
            return mrq_pkg::CMD_ENQUEUE;
        return ($urandom_range(0, 99) < 60) ? mrq_pkg::CMD_REMOVE_MIN
                                            : mrq_pkg::CMD_REMOVE_FRONT;
    endfunction

    // offer one command and return at the edge that takes it
    task automatic send_cmd(input logic [mrq_pkg::CMD_W-1:0] code,
                            input mrq_pkg::value_t           val,
                            input bit                        quiet);
        int gap;
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= code;
        cmd_if.value   <= val;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        commands_sent++;
        gap = quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random ready pattern plus one long hold-off
    initial
    begin
        int  high_run;
        int  low_run;
        bit  held_off;
        held_off = 1'b0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_OFF_AFTER)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            res_if.ready <= 1'b1;
            high_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            repeat (high_run) @(posedge clk);
            low_run = gap_len();
            if (low_run > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (low_run) @(posedge clk);
            end
        end
    end

    initial
    begin
        traffic_phase_t phase;
        int             phase_left;
        bit             quiet;
        rst_n          <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= mrq_pkg::CMD_ENQUEUE;
        cmd_if.value   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removals and the unused code on an empty queue
        send_cmd(mrq_pkg::CMD_REMOVE_MIN, VAL_MAX, 1'b0);
        send_cmd(mrq_pkg::CMD_REMOVE_FRONT, VAL_MIN, 1'b0);
        send_cmd(CMD_UNUSED, -1, 1'b0);
        // extremes and a tie on -1
        send_cmd(mrq_pkg::CMD_ENQUEUE, VAL_MAX, 1'b0);
        send_cmd(mrq_pkg::CMD_ENQUEUE, VAL_MIN, 1'b0);
        send_cmd(mrq_pkg::CMD_ENQUEUE, -1, 1'b0);
        send_cmd(mrq_pkg::CMD_ENQUEUE, 5, 1'b0);
        send_cmd(mrq_pkg::CMD_ENQUEUE, -1, 1'b0);
        send_cmd(mrq_pkg::CMD_REMOVE_MIN, '0, 1'b0);
        send_cmd(mrq_pkg::CMD_REMOVE_MIN, '0, 1'b0);
        // front removal takes the oldest entry, VAL_MAX
        send_cmd(mrq_pkg::CMD_REMOVE_FRONT, '0, 1'b0);
        // fill to the top, then overflow and the unused code when full
        for (int i = 0; i < mrq_pkg::DEPTH - 2; i++)
            send_cmd(mrq_pkg::CMD_ENQUEUE, mrq_pkg::value_t'(i * 3 - 20), 1'b0);
        send_cmd(mrq_pkg::CMD_ENQUEUE, VAL_MAX, 1'b0);
        send_cmd(CMD_UNUSED, VAL_MIN, 1'b0);

        phase      = PH_DRAIN;
        phase_left = 0;
        quiet      = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase      = traffic_phase_t'($urandom_range(0, 2));
                phase_left = $urandom_range(10, 60);
                quiet      = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            send_cmd(random_command(phase), random_value(), quiet);
        end

        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands driven, %0d results checked", commands_sent, results_seen);
        $display("%0d enqueues refused on a full queue, %0d removals from an empty queue",
                 full_drops, empty_hits);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
